/* design/cbp_pkg.sv */
// cbp_pkg: shared constants for the circle/box push-out block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cbp_pkg;
    localparam int WALL_SLOTS_DEF = 16;
    localparam int COORD_BITS_DEF = 24;
    localparam int CFG_BITS       = 23;
    localparam int COUNT_BITS     = 5;
    localparam logic [63:0] EPS_SQ = 64'd1677;

    localparam logic [1:0] REG_ARENA_HALF  = 2'd0;
    localparam logic [1:0] REG_RADIUS      = 2'd1;
    localparam logic [1:0] REG_WALL_COUNT  = 2'd2;

    localparam logic REQ_RESOLVE = 1'b0;
    localparam logic REQ_WALL    = 1'b1;
endpackage
`default_nettype wire

/* design/cbp_wall_cell.sv */
// cbp_wall_cell: one storage cell of the wall ring; holds one wall's bounds.
// Loads from the write port or from its neighbor when the ring rotates.
`timescale 1ns / 1ps
`default_nettype none
module cbp_wall_cell #(
    parameter int W = 96
) (
    input  wire logic         i_clk,
    input  wire logic         i_shift,
    input  wire logic         i_load,
    input  wire logic [W-1:0] i_load_data,
    input  wire logic [W-1:0] i_next_data,
    output logic      [W-1:0] o_data
);
    logic [W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_next_data;
        end else if (i_load) begin
            r_data <= i_load_data;
        end
    end

    assign o_data = r_data;
endmodule
`default_nettype wire

/* design/cbp_engine.sv */
// cbp_engine: sequential resolve engine (clamp, per-wall distance, sqrt, divide).
// Depends on cbp_pkg; reads the wall at the head of the ring and rotates it.
`timescale 1ns / 1ps
`default_nettype none
module cbp_engine #(
    parameter int WALL_SLOTS = cbp_pkg::WALL_SLOTS_DEF,
    parameter int COORD_BITS = cbp_pkg::COORD_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic signed [COORD_BITS-1:0]   i_pos_x,
    input  wire logic signed [COORD_BITS-1:0]   i_pos_z,
    input  wire logic [cbp_pkg::CFG_BITS-1:0]   i_half,
    input  wire logic [cbp_pkg::CFG_BITS-1:0]   i_radius,
    input  wire logic [cbp_pkg::COUNT_BITS-1:0] i_wall_count,
    input  wire logic [4*COORD_BITS-1:0]        i_wall,
    output logic                                o_shift,
    output logic                                o_busy,
    output logic                                o_valid,
    output logic signed [COORD_BITS-1:0]        o_new_x,
    output logic signed [COORD_BITS-1:0]        o_new_z
);
    localparam int CW  = COORD_BITS;
    localparam int EW  = ((CW > cbp_pkg::CFG_BITS) ? CW : cbp_pkg::CFG_BITS) + 3;
    localparam int DW  = 2 * EW;
    localparam int PW  = 2 * EW;
    localparam int SW  = $clog2(PW + 1);
    localparam int NW  = $clog2(WALL_SLOTS + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLAMP, ST_WALL, ST_SQX, ST_SQZ, ST_SUM, ST_DEC,
        ST_SQRT, ST_MUL, ST_DIV, ST_NEXT, ST_RESTORE
    } t_state;

    t_state r_state;
    logic signed [CW-1:0] r_px, r_pz, r_inx, r_inz;
    logic signed [EW-1:0] r_dx, r_dz;
    logic [DW-1:0] r_ax, r_az, r_dsq, r_r2, r_rad;
    logic [EW+1:0] r_srem;
    logic [EW-1:0] r_root;
    logic [PW-1:0] r_quo;
    logic [EW-1:0] r_drem;
    logic [SW-1:0] r_step;
    logic [NW-1:0] r_widx, r_rot;
    logic          r_axis;
    logic          r_valid;

    function automatic logic signed [EW-1:0] f_ext(input logic signed [CW-1:0] v);
        f_ext = {{(EW-CW){v[CW-1]}}, v};
    endfunction

    function automatic logic signed [CW-1:0] f_sat(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] hi, lo;
        hi = {{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}};
        lo = ~hi;
        if (v < lo) f_sat = lo[CW-1:0];
        else if (v > hi) f_sat = hi[CW-1:0];
        else f_sat = v[CW-1:0];
    endfunction

    function automatic logic signed [EW-1:0] f_clamp(input logic signed [EW-1:0] v,
                                                     input logic signed [EW-1:0] lo,
                                                     input logic signed [EW-1:0] hi);
        if (v < lo) f_clamp = lo;
        else if (v > hi) f_clamp = hi;
        else f_clamp = v;
    endfunction

    logic signed [EW-1:0] w_half, w_r, w_mnx, w_mxx, w_mnz, w_mxz;
    logic signed [EW-1:0] w_dx, w_dz, w_c0, w_c1, w_c2, w_c3;
    logic [EW-1:0] w_adx, w_adz, w_push, w_ad_sel;
    logic [6:0] w_n;
    logic [EW+1:0] w_srem2, w_trial;
    logic [EW:0] w_drem2;
    logic signed [EW-1:0] w_q, w_psel;

    assign w_half = EW'(i_half);
    assign w_r    = EW'(i_radius);
    assign w_mnx  = f_ext(i_wall[4*CW-1:3*CW]);
    assign w_mxx  = f_ext(i_wall[3*CW-1:2*CW]);
    assign w_mnz  = f_ext(i_wall[2*CW-1:CW]);
    assign w_mxz  = f_ext(i_wall[CW-1:0]);
    assign w_dx   = f_ext(r_px) - f_clamp(f_ext(r_px), w_mnx, w_mxx);
    assign w_dz   = f_ext(r_pz) - f_clamp(f_ext(r_pz), w_mnz, w_mxz);
    assign w_adx  = r_dx[EW-1] ? EW'(-r_dx) : EW'(r_dx);
    assign w_adz  = r_dz[EW-1] ? EW'(-r_dz) : EW'(r_dz);
    assign w_push = EW'(w_r - $signed(r_root));
    assign w_ad_sel = r_axis ? w_adz : w_adx;
    assign w_n = (7'(i_wall_count) < 7'(WALL_SLOTS)) ? 7'(i_wall_count) : 7'(WALL_SLOTS);

    assign w_c0 = f_ext(r_px) - w_mnx + w_r;
    assign w_c1 = w_mxx - f_ext(r_px) + w_r;
    assign w_c2 = f_ext(r_pz) - w_mnz + w_r;
    assign w_c3 = w_mxz - f_ext(r_pz) + w_r;

    assign w_srem2 = {r_srem[EW-1:0], r_rad[DW-1:DW-2]};
    assign w_trial = {r_root, 2'b01};
    assign w_drem2 = {r_drem, r_quo[PW-1]};

    assign w_q    = (r_axis ? r_dz[EW-1] : r_dx[EW-1]) ? -$signed(r_quo[EW-1:0])
                                                       : $signed(r_quo[EW-1:0]);
    assign w_psel = (r_axis ? f_ext(r_pz) : f_ext(r_px)) + w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_inx   <= i_pos_x;
                        r_inz   <= i_pos_z;
                        r_state <= ST_CLAMP;
                    end
                end
                ST_CLAMP: begin
                    r_px    <= f_sat(f_clamp(f_ext(r_inx), w_r - w_half, w_half - w_r));
                    r_pz    <= f_sat(f_clamp(f_ext(r_inz), w_r - w_half, w_half - w_r));
                    r_r2    <= DW'(i_radius) * DW'(i_radius);
                    r_widx  <= '0;
                    r_rot   <= '0;
                    r_state <= ST_WALL;
                end
                ST_WALL: begin
                    r_dx <= w_dx;
                    r_dz <= w_dz;
                    if (7'(r_widx) == w_n) r_state <= ST_RESTORE;
                    else r_state <= ST_SQX;
                end
                ST_SQX: begin
                    r_ax    <= DW'(w_adx) * DW'(w_adx);
                    r_state <= ST_SQZ;
                end
                ST_SQZ: begin
                    r_az    <= DW'(w_adz) * DW'(w_adz);
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_dsq   <= r_ax + r_az;
                    r_state <= ST_DEC;
                end
                ST_DEC: begin
                    r_rad  <= r_dsq;
                    r_srem <= '0;
                    r_root <= '0;
                    r_step <= '0;
                    r_axis <= 1'b0;
                    if (r_dsq < r_r2 && r_dsq > DW'(cbp_pkg::EPS_SQ)) begin
                        r_state <= ST_SQRT;
                    end else begin
                        if (r_dsq < DW'(cbp_pkg::EPS_SQ)) begin
                            priority if (w_c3 < w_c0 && w_c3 < w_c1 && w_c3 < w_c2)
                                r_pz <= f_sat(w_mxz + w_r);
                            else if (w_c2 < w_c0 && w_c2 < w_c1)
                                r_pz <= f_sat(w_mnz - w_r);
                            else if (w_c1 < w_c0)
                                r_px <= f_sat(w_mxx + w_r);
                            else
                                r_px <= f_sat(w_mnx - w_r);
                        end
                        r_state <= ST_NEXT;
                    end
                end
                ST_SQRT: begin
                    if (w_srem2 >= w_trial) begin
                        r_srem <= w_srem2 - w_trial;
                        r_root <= {r_root[EW-2:0], 1'b1};
                    end else begin
                        r_srem <= w_srem2;
                        r_root <= {r_root[EW-2:0], 1'b0};
                    end
                    r_rad  <= {r_rad[DW-3:0], 2'b00};
                    r_step <= r_step + 1'b1;
                    if (r_step == SW'(EW - 1)) r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_quo   <= PW'(w_ad_sel) * PW'(w_push);
                    r_drem  <= '0;
                    r_step  <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (r_step == SW'(PW)) begin
                        if (r_axis) begin
                            r_pz    <= f_sat(w_psel);
                            r_state <= ST_NEXT;
                        end else begin
                            r_px    <= f_sat(w_psel);
                            r_axis  <= 1'b1;
                            r_state <= ST_MUL;
                        end
                    end else begin
                        if (w_drem2 >= {1'b0, r_root}) begin
                            r_drem <= EW'(w_drem2 - {1'b0, r_root});
                            r_quo  <= {r_quo[PW-2:0], 1'b1};
                        end else begin
                            r_drem <= w_drem2[EW-1:0];
                            r_quo  <= {r_quo[PW-2:0], 1'b0};
                        end
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_NEXT: begin
                    r_widx  <= r_widx + 1'b1;
                    r_rot   <= r_rot + 1'b1;
                    r_state <= ST_WALL;
                end
                ST_RESTORE: begin
                    if (r_rot == NW'(WALL_SLOTS)) begin
                        r_valid <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_rot <= r_rot + 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_shift = (r_state == ST_NEXT) ||
                     (r_state == ST_RESTORE && r_rot != NW'(WALL_SLOTS));
    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_new_x = r_px;
    assign o_new_z = r_pz;
endmodule
`default_nettype wire

/* design/circle_box_pushout_top.sv */
// circle_box_pushout_top: ring of wall cells plus the resolve engine.
// Wall write: no result; the next request may follow in the next cycle.
// Resolve: the strobe comes once the ring is rotated back to its start; n walls are visited,
// k of them pushed radially by a square root and then a divider for each axis.
// One request at a time; busy drops in the strobe cycle. Result is not stalled.
// Reset (synchronous, active low) restores register defaults; the wall table is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module circle_box_pushout_top #(
    parameter int WALL_SLOTS = cbp_pkg::WALL_SLOTS_DEF,
    parameter int COORD_BITS = cbp_pkg::COORD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         i_req_type,
    input  wire logic [3:0]                   i_wall_index,
    input  wire logic signed [COORD_BITS-1:0] i_wall_min_x,
    input  wire logic signed [COORD_BITS-1:0] i_wall_max_x,
    input  wire logic signed [COORD_BITS-1:0] i_wall_min_z,
    input  wire logic signed [COORD_BITS-1:0] i_wall_max_z,
    input  wire logic signed [COORD_BITS-1:0] i_pos_x,
    input  wire logic signed [COORD_BITS-1:0] i_pos_z,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [1:0]                   i_cfg_index,
    input  wire logic [cbp_pkg::CFG_BITS-1:0] i_cfg_data,
    output logic                              o_valid,
    output logic signed [COORD_BITS-1:0]      o_new_x,
    output logic signed [COORD_BITS-1:0]      o_new_z
);
    localparam int WW = 4 * COORD_BITS;

    logic [cbp_pkg::CFG_BITS-1:0]   r_half, r_radius;
    logic [cbp_pkg::COUNT_BITS-1:0] r_wall_count;
    logic w_accept, w_shift, w_write;
    logic [WW-1:0] w_cell [WALL_SLOTS];
    logic [WW-1:0] w_load;

    assign w_accept    = start && !busy;
    assign w_write     = w_accept && (i_req_type == cbp_pkg::REQ_WALL);
    assign w_load      = {i_wall_min_x, i_wall_max_x, i_wall_min_z, i_wall_max_z};
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half       <= cbp_pkg::CFG_BITS'(163840);
            r_radius     <= cbp_pkg::CFG_BITS'(2048);
            r_wall_count <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cbp_pkg::REG_ARENA_HALF: r_half   <= i_cfg_data;
                cbp_pkg::REG_RADIUS:     r_radius <= i_cfg_data;
                cbp_pkg::REG_WALL_COUNT:
                    r_wall_count <= i_cfg_data[cbp_pkg::COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    genvar k;
    generate
        for (k = 0; k < WALL_SLOTS; k++) begin : g_cell
            cbp_wall_cell #(.W(WW)) u_cell (
                .i_clk       (i_clk),
                .i_shift     (w_shift),
                .i_load      (w_write && (7'(i_wall_index) == 7'(k))),
                .i_load_data (w_load),
                .i_next_data (w_cell[(k + 1) % WALL_SLOTS]),
                .o_data      (w_cell[k])
            );
        end
    endgenerate

    cbp_engine #(
        .WALL_SLOTS (WALL_SLOTS),
        .COORD_BITS (COORD_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_accept && (i_req_type == cbp_pkg::REQ_RESOLVE)),
        .i_pos_x      (i_pos_x),
        .i_pos_z      (i_pos_z),
        .i_half       (r_half),
        .i_radius     (r_radius),
        .i_wall_count (r_wall_count),
        .i_wall       (w_cell[0]),
        .o_shift      (w_shift),
        .o_busy       (busy),
        .o_valid      (o_valid),
        .o_new_x      (o_new_x),
        .o_new_z      (o_new_z)
    );
endmodule
`default_nettype wire
